// ===== hw/rtl/dsd_pkg.sv =====
// Shared constants and types for the dielectric scatter direction block.
// No dependencies; imported by the top level.
package dsd_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int RI_W       = 14;
    localparam int EPS_W      = 10;
    localparam int RND_W      = 16;
    localparam int RI_FRAC    = 12;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_REFR_INDEX = 1'b0;
    localparam t_cfg_idx REG_REFR_EPS   = 1'b1;

    localparam logic [RI_W-1:0]  RI_RESET  = 14'd6144;
    localparam logic [EPS_W-1:0] EPS_RESET = 10'd1;

endpackage

// ===== hw/rtl/dsd_udiv.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; instantiated by the top level.
module dsd_udiv #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_den
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar j = 0; j < NW; j++) begin : g_st
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [NW-1:0] num_prev;
        logic [NW-1:0] quo_prev;
        logic [DW:0]   rem_in;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;

        if (j == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = i_num;
            assign quo_prev = '0;
            assign den_prev = i_den;
        end else begin : g_next
            assign rem_prev = r_rem[j-1];
            assign num_prev = r_num[j-1];
            assign quo_prev = r_quo[j-1];
            assign den_prev = r_den[j-1];
        end

        always_comb begin
            rem_in = {rem_prev, num_prev[NW-1]};
            diff   = rem_in - {1'b0, den_prev};
            ge     = (rem_in >= {1'b0, den_prev});
            n_rem  = ge ? diff[DW-1:0] : rem_in[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_num[j] <= num_prev << 1;
                r_quo[j] <= {quo_prev[NW-2:0], ge};
                r_den[j] <= den_prev;
            end
        end
    end

    assign o_quo = r_quo[NW-1];
    assign o_den = r_den[NW-1];

endmodule

// ===== hw/rtl/dsd_isqrt.sv =====
// Pipelined floor integer square root, one root bit per stage.
// Standalone; instantiated by the top level.
module dsd_isqrt #(
    parameter int VW = 8
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [VW-1:0]   i_val,
    output logic [VW/2-1:0] o_root
);

    localparam int RW = VW / 2;

    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [VW-1:0] r_val  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_st
        logic [RW+1:0] rem_prev;
        logic [RW-1:0] root_prev;
        logic [VW-1:0] val_prev;
        logic [RW+1:0] rem_in;
        logic [RW+1:0] trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = i_val;
        end else begin : g_next
            assign rem_prev  = r_rem[j-1];
            assign root_prev = r_root[j-1];
            assign val_prev  = r_val[j-1];
        end

        always_comb begin
            rem_in = {rem_prev[RW-1:0], val_prev[VW-1 -: 2]};
            trial  = {root_prev, 2'b01};
            ge     = (rem_in >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? (rem_in - trial) : rem_in;
                r_root[j] <= {root_prev[RW-2:0], ge};
                r_val[j]  <= val_prev << 2;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== hw/rtl/dielectric_scatter_direction.sv =====
// Top level: glass surface scatter direction, one ray per cycle when not stalled, through a deep pipeline.
// Depends on dsd_pkg, dsd_udiv and dsd_isqrt.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------------
//  s        | in        | tdata: dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, rand_frac
//  m        | out       | tdata: out_x, out_y, out_z; tuser: took_reflection,
//           |           |        total_internal, saturated
//  cfg      | in        | index, data: refractive_index (0), refract_epsilon (1)
//
// Pipeline depth is set by the length sqrt, the three per-lane unit-vector dividers and
// the Snell root, whose sizes follow I = min(COMPONENT_WIDTH-2, 22).
// One item enters per cycle; a stall on the output freezes the whole pipeline.
// After reset and after every register write the input holds off while the
// index reciprocal and the Schlick base term settle in their dividers.
module dielectric_scatter_direction #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, rand_frac, zero pad
    input  logic [((6*COMPONENT_WIDTH+16+7)/8)*8-1:0] i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // took_reflection, total_internal, saturated
    output logic [2:0]            o_m_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  dsd_pkg::t_cfg_idx     i_cfg_index,
    input  dsd_pkg::t_cfg_data    i_cfg_data
);
    import dsd_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int FB    = CW - 2;
    localparam int IB    = (FB < 22) ? FB : 22;
    localparam int DS    = FB - IB;
    localparam int QW    = IB + 9;
    localparam int PW    = 2 * QW;
    localparam int SW    = 2 * QW + 2;
    localparam int L2W   = 2 * IB + 4;
    localparam int LENW  = IB + 2;
    localparam int UNW   = 2 * IB + 2;
    localparam int RTW   = IB + 4;
    localparam int R2VW  = 2 * IB + 8;
    localparam int KNW   = IB + 13;
    localparam int QNW   = 2 * IB + 2;
    localparam int QDW   = IB + 3;
    localparam int TW    = QW + 15;
    localparam int OWB   = ((3 * CW + 7) / 8) * 8;
    localparam int CFG_LAT = ((KNW > QNW) ? KNW : QNW) + 1;
    localparam int CNTW  = $clog2(CFG_LAT + 1);

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [SW-1:0] t_w;
    typedef logic [L2W-1:0]       t_l2;

    localparam t_w QLIM_W = (t_w'(1) <<< (IB + 8)) - t_w'(1);
    localparam t_w QONE_W = t_w'(1) <<< IB;
    localparam t_w CMAX_W = (t_w'(1) <<< (CW - 1)) - t_w'(1);
    localparam t_w CMIN_W = -(t_w'(1) <<< (CW - 1));
    localparam t_q QLIM   = t_q'(QLIM_W);
    localparam t_q QONE   = t_q'(QONE_W);
    localparam logic [IB+1:0] ONE_R = (IB + 2)'(1) << IB;

    typedef struct {
        t_q              d [3];
        t_q              nv [3];
        logic [RND_W-1:0] rnd;
        t_l2             sq [3];
        t_l2             len2;
        t_q              dn;
        t_q              mp [3];
        t_q              k;
        t_q              onrm [3];
        t_q              mir [3];
        t_q              unit [3];
        t_q              c1;
        t_q              kk;
        t_q              r0;
        t_q              omr;
        t_q              kc;
        t_q              ku [3];
        t_q              sin2;
        t_q              x;
        t_q              p;
        t_q              disc;
        logic            tir;
        t_q              prob;
        t_q              along;
        logic            take;
        t_q              mo [3];
    } t_bun;

    function automatic t_q sat(input t_w v);
        return (v > QLIM_W) ? QLIM : ((v < -QLIM_W) ? -QLIM : t_q'(v));
    endfunction

    function automatic t_w wx(input t_q a);
        return t_w'(a);
    endfunction

    function automatic t_q fmul(input t_q a, input t_q b);
        logic signed [PW-1:0] p;
        p = a * b;
        return sat(t_w'(p >>> IB));
    endfunction

    function automatic logic [LENW-1:0] absd(input t_q v);
        t_q a;
        a = (v < 0) ? -v : v;
        return a[LENW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [RI_W-1:0]  r_ri;
    logic [EPS_W-1:0] r_eps;
    logic [CNTW-1:0]  r_cfg_wait;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ri       <= RI_RESET;
            r_eps      <= EPS_RESET;
            r_cfg_wait <= CNTW'(CFG_LAT);
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_REFR_INDEX: r_ri  <= i_cfg_data[RI_W-1:0];
                    REG_REFR_EPS:   r_eps <= i_cfg_data[EPS_W-1:0];
                endcase
                r_cfg_wait <= CNTW'(CFG_LAT);
            end else if (r_cfg_wait != '0) begin
                r_cfg_wait <= r_cfg_wait - 1'b1;
            end
        end
    end

    logic [RI_W-1:0]    ri_eff;
    logic [RI_W+IB-1:0] ri_full;
    logic [IB+1:0]      ri_w;
    logic               q_neg;
    logic [IB+1:0]      q_mag;
    logic [KNW-1:0]     kinv_quo;
    logic [QNW-1:0]     qb_quo;
    t_q                 ri_q;
    t_q                 kinv_q;
    t_q                 qb_mag;
    t_q                 qc_q;
    t_q                 epsq_q;

    always_comb begin
        ri_eff  = (r_ri == '0) ? RI_W'(1) : r_ri;
        ri_full = {ri_eff, {IB{1'b0}}};
        ri_w    = ri_full[RI_W+IB-1:RI_FRAC];
        ri_q    = t_q'(ri_w);
        q_neg   = (ri_w > ONE_R);
        q_mag   = q_neg ? (ri_w - ONE_R) : (ONE_R - ri_w);
        kinv_q  = (kinv_quo > KNW'(QLIM)) ? QLIM : t_q'(kinv_quo);
        qb_mag  = (qb_quo > QNW'(QLIM)) ? QLIM : t_q'(qb_quo);
        qc_q    = q_neg ? -qb_mag : qb_mag;
        epsq_q  = t_q'(r_eps >> DS);
    end

    dsd_udiv #(.NW(KNW), .DW(RI_W)) u_kinv_div (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_num (KNW'(1) << (IB + RI_FRAC)),
        .i_den (ri_eff),
        .o_quo (kinv_quo),
        .o_den ()
    );

    dsd_udiv #(.NW(QNW), .DW(QDW)) u_schlick_div (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_num ({q_mag, {IB{1'b0}}}),
        .i_den (QDW'(ri_w) + QDW'(ONE_R)),
        .o_quo (qb_quo),
        .o_den ()
    );

    // ---------------- pipeline control ----------------
    logic r_ovalid;
    logic adv;

    assign adv        = !r_ovalid || i_m_tready;
    assign o_s_tready = adv && (r_cfg_wait == '0);

    t_bun n_p0, n_p1, n_p2, n_p3, n_p4, n_p5, n_p6, n_p7;
    t_bun n_p8, n_p9, n_p10, n_p11, n_p12, n_p13, n_p14;
    t_bun r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;
    t_bun r_p8, r_p9, r_p10, r_p11, r_p12, r_p13, r_p14;
    logic [14:0] r_v;

    t_bun r_d1 [LENW];
    t_bun r_d2 [UNW];
    t_bun r_d3 [RTW];
    logic r_d1v [LENW];
    logic r_d2v [UNW];
    logic r_d3v [RTW];

    logic [LENW-1:0] w_len;
    logic [UNW-1:0]  w_quo [3];
    logic [LENW-1:0] w_den [3];
    logic [RTW-1:0]  w_root;

    // input capture
    always_comb begin
        n_p0 = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            n_p0.d[i]  = t_q'(signed'(i_s_tdata[i*CW +: CW]) >>> DS);
            n_p0.nv[i] = t_q'(signed'(i_s_tdata[(3+i)*CW +: CW]) >>> DS);
        end
        n_p0.rnd = i_s_tdata[6*CW +: RND_W];
    end

    // products for the incidence dot and the squared length
    always_comb begin
        logic signed [PW-1:0] sqp;
        n_p1 = r_p0;
        for (int i = 0; i < 3; i++) begin
            n_p1.mp[i] = fmul(r_p0.d[i], r_p0.nv[i]);
            sqp        = r_p0.d[i] * r_p0.d[i];
            n_p1.sq[i] = t_l2'(sqp);
        end
    end

    always_comb begin
        n_p2      = r_p1;
        n_p2.dn   = sat(wx(r_p1.mp[0]) + wx(r_p1.mp[1]) + wx(r_p1.mp[2]));
        n_p2.len2 = r_p1.sq[0] + r_p1.sq[1] + r_p1.sq[2];
    end

    dsd_isqrt #(.VW(L2W)) u_len_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r_p2.len2),
        .o_root (w_len)
    );

    for (genvar g = 0; g < 3; g++) begin : g_unit
        dsd_udiv #(.NW(UNW), .DW(LENW)) u_unit_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num ({absd(r_d1[LENW-1].d[g]), {IB{1'b0}}}),
            .i_den (w_len),
            .o_quo (w_quo[g]),
            .o_den (w_den[g])
        );
    end

    // unit vector, mirror product, side selection
    always_comb begin
        t_q  um;
        logic leave;
        n_p3  = r_d2[UNW-1];
        leave = (r_d2[UNW-1].dn > epsq_q);
        n_p3.k = leave ? ri_q : kinv_q;
        for (int i = 0; i < 3; i++) begin
            um = (w_quo[i] > UNW'(QLIM)) ? QLIM : t_q'(w_quo[i]);
            if (w_den[i] == '0) begin
                n_p3.unit[i] = '0;
            end else begin
                n_p3.unit[i] = (r_d2[UNW-1].d[i] < 0) ? -um : um;
            end
            n_p3.mp[i]   = fmul(r_d2[UNW-1].dn, r_d2[UNW-1].nv[i]);
            n_p3.onrm[i] = leave ? -r_d2[UNW-1].nv[i] : r_d2[UNW-1].nv[i];
        end
    end

    always_comb begin
        n_p4 = r_p3;
        for (int i = 0; i < 3; i++) begin
            n_p4.mir[i] = sat(wx(r_p3.d[i]) - (wx(r_p3.mp[i]) <<< 1));
            n_p4.mp[i]  = fmul(r_p3.unit[i], r_p3.onrm[i]);
        end
        n_p4.kk = fmul(r_p3.k, r_p3.k);
        n_p4.r0 = fmul(qc_q, qc_q);
    end

    always_comb begin
        n_p5     = r_p4;
        n_p5.c1  = -sat(wx(r_p4.mp[0]) + wx(r_p4.mp[1]) + wx(r_p4.mp[2]));
        n_p5.omr = sat(QONE_W - wx(r_p4.r0));
    end

    always_comb begin
        n_p6      = r_p5;
        n_p6.sin2 = fmul(r_p5.c1, r_p5.c1);
        n_p6.kc   = fmul(r_p5.k, r_p5.c1);
        for (int i = 0; i < 3; i++) begin
            n_p6.ku[i] = fmul(r_p5.k, r_p5.unit[i]);
        end
    end

    always_comb begin
        n_p7      = r_p6;
        n_p7.sin2 = sat(QONE_W - wx(r_p6.sin2));
        n_p7.x    = sat(QONE_W - wx(r_p6.kc));
    end

    always_comb begin
        n_p8      = r_p7;
        n_p8.disc = sat(QONE_W - wx(fmul(r_p7.kk, r_p7.sin2)));
        n_p8.p    = fmul(r_p7.x, r_p7.x);
    end

    always_comb begin
        n_p9     = r_p8;
        n_p9.tir = !(r_p8.disc > epsq_q);
        n_p9.p   = fmul(r_p8.p, r_p8.p);
    end

    always_comb begin
        n_p10   = r_p9;
        n_p10.p = fmul(r_p9.p, r_p9.x);
    end

    always_comb begin
        n_p11   = r_p10;
        n_p11.p = fmul(r_p10.omr, r_p10.p);
    end

    // total internal reflection forces the mirror path
    always_comb begin
        n_p12      = r_p11;
        n_p12.prob = r_p11.tir ? QONE : sat(wx(r_p11.r0) + wx(r_p11.p));
    end

    dsd_isqrt #(.VW(R2VW)) u_snell_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r_p12.tir ? R2VW'(0) : {r_p12.disc[IB+7:0], {IB{1'b0}}}),
        .o_root (w_root)
    );

    always_comb begin
        n_p13       = r_d3[RTW-1];
        n_p13.along = sat(wx(r_d3[RTW-1].kc) - t_w'(w_root));
        n_p13.take  = !r_d3[RTW-1].prob[QW-1] &&
                      (TW'({r_d3[RTW-1].rnd, {IB{1'b0}}}) <=
                       TW'({r_d3[RTW-1].prob[QW-2:0], 16'b0}));
    end

    always_comb begin
        n_p14 = r_p13;
        for (int i = 0; i < 3; i++) begin
            n_p14.mo[i] = fmul(r_p13.onrm[i], r_p13.along);
        end
    end

    // output select and clamp to component width
    logic [CW-1:0] n_o [3];
    logic          n_clip;
    logic [CW-1:0] r_o [3];
    logic          r_took;
    logic          r_tir;
    logic          r_sat;

    always_comb begin
        t_q refr;
        t_q sel;
        t_w v;
        t_w c;
        n_clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            refr   = r_p14.tir ? t_q'(0) : sat(wx(r_p14.ku[i]) + wx(r_p14.mo[i]));
            sel    = r_p14.take ? r_p14.mir[i] : refr;
            v      = wx(sel) <<< DS;
            c      = (v > CMAX_W) ? CMAX_W : ((v < CMIN_W) ? CMIN_W : v);
            n_clip = n_clip | (c != v);
            n_o[i] = c[CW-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < LENW; k++) r_d1v[k] <= 1'b0;
            for (int k = 0; k < UNW; k++)  r_d2v[k] <= 1'b0;
            for (int k = 0; k < RTW; k++)  r_d3v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_s_tvalid && o_s_tready;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_d1v[0] <= r_v[2];
            for (int k = 1; k < LENW; k++) r_d1v[k] <= r_d1v[k-1];
            r_d2v[0] <= r_d1v[LENW-1];
            for (int k = 1; k < UNW; k++) r_d2v[k] <= r_d2v[k-1];
            r_v[3] <= r_d2v[UNW-1];
            for (int k = 4; k <= 12; k++) r_v[k] <= r_v[k-1];
            r_d3v[0] <= r_v[12];
            for (int k = 1; k < RTW; k++) r_d3v[k] <= r_d3v[k-1];
            r_v[13]  <= r_d3v[RTW-1];
            r_v[14]  <= r_v[13];
            r_ovalid <= r_v[14];
        end
    end

    // payload; hold everything while stalled
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_d1[0] <= r_p2;
            for (int k = 1; k < LENW; k++) r_d1[k] <= r_d1[k-1];
            r_d2[0] <= r_d1[LENW-1];
            for (int k = 1; k < UNW; k++) r_d2[k] <= r_d2[k-1];
            r_p3  <= n_p3;
            r_p4  <= n_p4;
            r_p5  <= n_p5;
            r_p6  <= n_p6;
            r_p7  <= n_p7;
            r_p8  <= n_p8;
            r_p9  <= n_p9;
            r_p10 <= n_p10;
            r_p11 <= n_p11;
            r_p12 <= n_p12;
            r_d3[0] <= r_p12;
            for (int k = 1; k < RTW; k++) r_d3[k] <= r_d3[k-1];
            r_p13 <= n_p13;
            r_p14 <= n_p14;
            for (int i = 0; i < 3; i++) r_o[i] <= n_o[i];
            r_took <= r_p14.take;
            r_tir  <= r_p14.tir;
            r_sat  <= n_clip;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OWB'({r_o[2], r_o[1], r_o[0]});
    assign o_m_tuser  = {r_sat, r_tir, r_took};

endmodule
